// ===== design/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the button debounce click detector
// Timer and tick widths, register indexes, state, config and event bundles,
// and the saturating timer add.
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int TICK_WIDTH  = 8;
  localparam int DELAY_WIDTH = 16;
  localparam int SUM_WIDTH   = ((TIMER_WIDTH > TICK_WIDTH) ? TIMER_WIDTH : TICK_WIDTH) + 1;
  localparam int CMP_WIDTH   = (TIMER_WIDTH > DELAY_WIDTH) ? TIMER_WIDTH : DELAY_WIDTH;

  localparam int IN_TDATA_WIDTH  = ((TICK_WIDTH + 1 + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = 8;
  localparam int CFG_ADDR_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  // Register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_DEBOUNCE_DELAY = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_DOUBLE_DELAY   = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_LONG_DELAY     = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_RELEASED_LEVEL = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_EVENTS_LOCKED  = 3'd4;

  // Settled level codes
  localparam logic [1:0] LVL_LOW     = 2'd0;
  localparam logic [1:0] LVL_HIGH    = 2'd1;
  localparam logic [1:0] LVL_UNKNOWN = 2'd2;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [TICK_WIDTH-1:0]  tick_t;

  typedef struct packed {
    logic [DELAY_WIDTH-1:0] settle_wait;
    logic [DELAY_WIDTH-1:0] click_window;
    logic [DELAY_WIDTH-1:0] hold_wait;
    logic                   released_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0] settled_level;
    logic       debounce_active;
    timer_t     debounce_elapsed;
    timer_t     click_elapsed;
    timer_t     press_elapsed;
    logic       pressed;
    logic       long_pressed;
    logic       clicked;
    logic       double_clicked;
    logic       click_pending;
  } state_t;

  // Bit order matches out_tdata, highest first
  typedef struct packed {
    logic release_click;
    logic release_event;
    logic double_click;
    logic press_event;
    logic long_hold;
    logic delayed_click;
  } events_t;

  // Register defaults: 20, 400 and 1000 ticks, released level high
  localparam cfg_t CFG_RESET = {DELAY_WIDTH'(20), DELAY_WIDTH'(400), DELAY_WIDTH'(1000), 1'b1};

  // Cleared state with the settled level unknown (settled_level is the top field)
  localparam state_t STATE_RESET = {LVL_UNKNOWN, {($bits(state_t)-2){1'b0}}};

  function automatic timer_t sat_add(timer_t a, tick_t t);
    logic [SUM_WIDTH-1:0] s;
    s = SUM_WIDTH'(a) + SUM_WIDTH'(t);
    if (s > SUM_WIDTH'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_WIDTH'(s);
  endfunction

  function automatic logic timer_ge(timer_t t, logic [DELAY_WIDTH-1:0] d);
    return CMP_WIDTH'(t) >= CMP_WIDTH'(d);
  endfunction

endpackage

// ===== design/button_debounce_click_detector.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_detector: debounced button with click event flags
// One poll in, one set of event flags out; press, release, long hold,
// double click, delayed single click and click on release.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | slave     | tvalid / tready    | tdata: tick_count, raw_level
//  out_    | master    | tvalid / tready    | tdata: six event flags
//  cfg_    | write     | cfg_we             | cfg_addr, cfg_wdata
//
// An item accepted at an edge has its result in the output register after
// that same edge; a new item is taken every cycle unless the output stalls.
// The state update of a poll is a single pass through bdc_step.
// Reset (rst_n low, synchronous) restores register defaults and clears state;
// the settled level starts unknown.
// A stalled result holds in the output register and blocks input until taken.
// ----------------------------------------------------------------------------
module button_debounce_click_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [7:0] tick_count, [8] raw_level, rest zero
  input  logic [bdc_pkg::IN_TDATA_WIDTH-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] delayed_click, [1] long_hold, [2] press_event, [3] double_click,
  // [4] release_event, [5] release_click, [7:6] zero
  output logic [bdc_pkg::OUT_TDATA_WIDTH-1:0]  out_tdata,
  input  logic                                 cfg_we,
  input  logic [bdc_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
  input  logic [bdc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);
  import bdc_pkg::*;

  cfg_t    cfg_r;
  logic    lock_r;
  state_t  state_r;
  state_t  state_nxt;
  events_t ev_nxt;
  events_t ev_r;
  logic    out_valid_r;
  logic    in_accept;

  // Output register frees up when empty or being drained this cycle
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_WIDTH'(ev_r);

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= CFG_RESET;
      lock_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE_DELAY: cfg_r.settle_wait    <= cfg_wdata[DELAY_WIDTH-1:0];
        REG_DOUBLE_DELAY:   cfg_r.click_window   <= cfg_wdata[DELAY_WIDTH-1:0];
        REG_LONG_DELAY:     cfg_r.hold_wait      <= cfg_wdata[DELAY_WIDTH-1:0];
        REG_RELEASED_LEVEL: cfg_r.released_level <= cfg_wdata[0];
        REG_EVENTS_LOCKED:  lock_r               <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Poll logic: debounce and event state machine
  bdc_step u_step (
    .cur   (state_r),
    .cfg   (cfg_r),
    .ticks (in_tdata[TICK_WIDTH-1:0]),
    .level (in_tdata[TICK_WIDTH]),
    .nxt   (state_nxt),
    .ev    (ev_nxt)
  );

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold all events at zero while locked
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ev_r <= lock_r ? '0 : ev_nxt;
    end
  end

  // A poll never reports press and release together
  a_press_xor_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ev_r.press_event && ev_r.release_event))
    else $error("press and release in one item");

  // A double click is only reported on a release
  a_double_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r.double_click) |-> ev_r.release_event)
    else $error("double click without release");

  // A shown press leaves the settled level at the pressed level
  a_press_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r.press_event) |->
      (state_r.settled_level == (cfg_r.released_level ? LVL_LOW : LVL_HIGH)))
    else $error("press event without pressed level");

  // A shown long hold leaves the long-pressed flag set
  a_long_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r.long_hold) |-> state_r.long_pressed)
    else $error("long hold without flag");

  // Locked block shows no events
  a_lock_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && lock_r) |=> (ev_r == '0))
    else $error("event while locked");

endmodule

// ===== design/bdc_step.sv =====
// ----------------------------------------------------------------------------
// bdc_step: next-state and event logic for one poll
// Debounce, then the press / release / click state machine on accepted levels.
// ----------------------------------------------------------------------------
module bdc_step (
  input  bdc_pkg::state_t  cur,
  input  bdc_pkg::cfg_t    cfg,
  input  bdc_pkg::tick_t   ticks,
  input  logic             level,
  output bdc_pkg::state_t  nxt,
  output bdc_pkg::events_t ev
);
  import bdc_pkg::*;

  always_comb begin
    logic accepted;
    logic is_released;
    logic suppress;
    logic [1:0] lvl_code;

    nxt         = cur;
    ev          = '0;
    accepted    = 1'b0;
    suppress    = 1'b0;
    lvl_code    = level ? LVL_HIGH : LVL_LOW;
    is_released = (level == cfg.released_level);

    // Debounce
    if (cur.debounce_active) begin
      nxt.debounce_elapsed = sat_add(cur.debounce_elapsed, ticks);
      accepted = timer_ge(nxt.debounce_elapsed, cfg.settle_wait);
      if (accepted) begin
        nxt.debounce_active = 1'b0;
      end
    end else if (lvl_code == cur.settled_level) begin
      accepted = 1'b1;
    end else begin
      nxt.debounce_active  = 1'b1;
      nxt.debounce_elapsed = '0;
    end

    if (accepted) begin
      if (cur.settled_level == LVL_UNKNOWN) begin
        nxt.settled_level = lvl_code;
      end else begin
        nxt.click_elapsed = sat_add(cur.click_elapsed, ticks);
        if (timer_ge(nxt.click_elapsed, cfg.click_window)) begin
          ev.delayed_click  = cur.click_pending;
          nxt.click_pending = 1'b0;
          nxt.clicked       = 1'b0;
        end
        nxt.press_elapsed = sat_add(cur.press_elapsed, ticks);
        if (!is_released && cur.pressed && !cur.long_pressed &&
            timer_ge(nxt.press_elapsed, cfg.hold_wait)) begin
          nxt.long_pressed = 1'b1;
          ev.long_hold     = 1'b1;
        end
        if (lvl_code != cur.settled_level) begin
          nxt.settled_level = lvl_code;
          if (!is_released) begin
            nxt.press_elapsed = '0;
            nxt.pressed       = 1'b1;
            ev.press_event    = 1'b1;
          end else begin
            // Release: short press counts as a click, second one as double
            if (!nxt.pressed || timer_ge(nxt.press_elapsed, cfg.click_window)) begin
              nxt.clicked = 1'b0;
            end else begin
              if (!nxt.clicked ||
                  timer_ge(nxt.click_elapsed, cfg.click_window)) begin
                nxt.double_clicked = 1'b0;
              end else begin
                nxt.click_pending  = 1'b0;
                nxt.double_clicked = 1'b1;
                ev.double_click    = 1'b1;
              end
              if (nxt.double_clicked) begin
                nxt.clicked = 1'b0;
              end else begin
                nxt.click_elapsed = '0;
                nxt.clicked       = 1'b1;
                nxt.click_pending = 1'b1;
              end
            end
            suppress           = nxt.long_pressed || nxt.clicked || nxt.double_clicked;
            nxt.pressed        = 1'b0;
            nxt.double_clicked = 1'b0;
            nxt.long_pressed   = 1'b0;
            ev.release_event   = 1'b1;
            ev.release_click   = !suppress;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the button debounce click detector
// Streams polls (tick count, raw level) into the block and predicts the
// event flags of every poll from a local model of the debouncer and the
// click state machine. It compares each result flag by flag and changes the
// registers between phases, with random gaps on the input side and random
// stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  import bdc_pkg::*;

  // Give up after this many cycles with no item moving on either side
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  // [7:0] tick_count, [8] raw_level, rest zero
  logic [IN_TDATA_WIDTH-1:0]   in_tdata   = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b1;
  // [0] delayed_click ... [5] release_click, [7:6] zero
  logic [OUT_TDATA_WIDTH-1:0]  out_tdata;
  logic                        cfg_we     = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0]   cfg_addr   = '0;
  logic [CFG_DATA_WIDTH-1:0]   cfg_wdata  = '0;

  // Register mirror, at reset values
  logic [DELAY_WIDTH-1:0] dly_debounce = 16'd20;
  logic [DELAY_WIDTH-1:0] dly_double   = 16'd400;
  logic [DELAY_WIDTH-1:0] dly_long     = 16'd1000;
  logic                   lvl_released = 1'b1;
  logic                   evt_lock     = 1'b0;

  // Button state mirror; the settled level starts unknown
  logic [1:0] lvl_settled   = LVL_UNKNOWN;
  logic       bouncing      = 1'b0;
  timer_t     bounce_ticks  = '0;
  timer_t     click_ticks   = '0;
  timer_t     hold_ticks    = '0;
  logic       is_pressed    = 1'b0;
  logic       is_long       = 1'b0;
  logic       is_clicked    = 1'b0;
  logic       is_double     = 1'b0;
  logic       click_waiting = 1'b0;

  events_t     awaited_flags[$];
  int          flag_errors  = 0;
  int          polls_sent   = 0;
  int          burst_left   = 0;
  int          idle_cycles  = 0;
  logic [5:0]  stall_phase  = '0;
  ready_mode_t ready_mode   = RDY_ALWAYS;
  logic [$bits(events_t)-1:0] want;

  string flag_names[$bits(events_t)] = '{"delayed_click", "long_hold", "press_event",
                                         "double_click", "release_event", "release_click"};

  button_debounce_click_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Timer add that sticks at all ones
  function automatic timer_t bump(timer_t t, tick_t d);
    logic [TIMER_WIDTH:0] s;
    s = {1'b0, t} + d;
    return s[TIMER_WIDTH] ? TIMER_MAX : s[TIMER_WIDTH-1:0];
  endfunction

  // Advance the button mirror by one poll and return the flags it raises
  function automatic events_t next_button_flags(tick_t ticks, logic raw);
    events_t    fl;
    logic       taken;
    logic       quiet;
    logic [1:0] raw_code;
    fl       = '0;
    taken    = 1'b0;
    raw_code = raw ? LVL_HIGH : LVL_LOW;

    // Debounce: a changed level waits, and the level seen when the wait ends wins
    if (bouncing) begin
      bounce_ticks = bump(bounce_ticks, ticks);
      taken = bounce_ticks >= dly_debounce;
      if (taken) bouncing = 1'b0;
    end else if (raw_code == lvl_settled) begin
      taken = 1'b1;
    end else begin
      bouncing     = 1'b1;
      bounce_ticks = '0;
    end

    if (taken) begin
      if (lvl_settled == LVL_UNKNOWN) begin
        // first level after reset is only recorded
        lvl_settled = raw_code;
      end else begin
        click_ticks = bump(click_ticks, ticks);
        if (click_waiting && click_ticks >= dly_double) begin
          fl.delayed_click = 1'b1;
          click_waiting    = 1'b0;
        end
        if (is_clicked && click_ticks >= dly_double) is_clicked = 1'b0;
        hold_ticks = bump(hold_ticks, ticks);
        if (raw != lvl_released && is_pressed && !is_long && hold_ticks >= dly_long) begin
          is_long      = 1'b1;
          fl.long_hold = 1'b1;
        end
        if (raw_code != lvl_settled) begin
          lvl_settled = raw_code;
          if (raw != lvl_released) begin
            hold_ticks     = '0;
            is_pressed     = 1'b1;
            fl.press_event = 1'b1;
          end else begin
            // release: short press is a click, second click in the window a double
            if (!is_pressed || hold_ticks >= dly_double) begin
              is_clicked = 1'b0;
            end else begin
              if (!is_clicked || click_ticks >= dly_double) begin
                is_double = 1'b0;
              end else begin
                click_waiting   = 1'b0;
                is_double       = 1'b1;
                fl.double_click = 1'b1;
              end
              if (is_double) begin
                is_clicked = 1'b0;
              end else begin
                click_ticks   = '0;
                is_clicked    = 1'b1;
                click_waiting = 1'b1;
              end
            end
            quiet            = is_long || is_clicked || is_double;
            is_pressed       = 1'b0;
            is_double        = 1'b0;
            is_long          = 1'b0;
            fl.release_event = 1'b1;
            fl.release_click = !quiet;
          end
        end
      end
    end

    if (evt_lock) fl = '0;
    return fl;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one poll, hold it until taken, then predict its flags
  task automatic send_poll(input tick_t ticks, input logic raw);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_WIDTH'({raw, ticks});
    do @(posedge clk); while (!in_tready);
    awaited_flags.push_back(next_button_flags(ticks, raw));
    polls_sent++;
    // Bursts of random length, then a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
    end
  endtask

  // Drop valid and wait until every flag set is back and the pipe is quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; the cycle after the write is left empty
  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_DEBOUNCE_DELAY: dly_debounce = data;
      REG_DOUBLE_DELAY:   dly_double   = data;
      REG_LONG_DELAY:     dly_long     = data;
      REG_RELEASED_LEVEL: lvl_released = data[0];
      REG_EVENTS_LOCKED:  evt_lock     = data[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random button activity: mostly clean press/release runs, some with contact
  // bounce, a few long holds and bursts of noise at full tick range
  task automatic run_gestures(input int n_polls, input int tick_max);
    int   start;
    int   kind;
    int   hold;
    logic lvl;
    start = polls_sent;
    lvl   = lvl_released;
    while (polls_sent - start < n_polls) begin
      kind = $urandom_range(0, 9);
      lvl  = ~lvl;
      if (kind == 9) begin
        repeat ($urandom_range(3, 10))
          send_poll(tick_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        if (kind >= 6 && kind <= 7) begin
          repeat ($urandom_range(1, 4))
            send_poll(tick_t'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
        end
        hold = (kind == 8) ? $urandom_range(15, 60) : $urandom_range(1, 12);
        repeat (hold) send_poll(tick_t'($urandom_range(0, tick_max)), lvl);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // First level after reset is recorded silently, then timers run
  task automatic test_first_level();
    send_poll(8'd0, lvl_released);
    send_poll(8'd255, lvl_released);
    send_poll(8'd7, lvl_released);
  endtask

  // Press, long hold, release with the click on release suppressed
  task automatic test_press_long_release();
    logic up;
    logic dn;
    up = lvl_released;
    dn = ~lvl_released;
    send_poll(8'd3, dn);
    send_poll(8'd20, dn);
    repeat (4) send_poll(8'd255, dn);
    send_poll(8'd0, up);
    send_poll(8'd25, up);
  endtask

  // Click, double click, single click resolved after the window, then a
  // press too long for a click that reports a click on release
  task automatic test_clicks();
    logic up;
    logic dn;
    up = lvl_released;
    dn = ~lvl_released;
    repeat (3) begin
      send_poll(8'd0, dn);
      send_poll(8'd20, dn);
      send_poll(8'd0, up);
      send_poll(8'd20, up);
    end
    send_poll(8'd255, up);
    send_poll(8'd255, up);
    send_poll(8'd0, dn);
    send_poll(8'd20, dn);
    send_poll(8'd255, dn);
    send_poll(8'd255, dn);
    send_poll(8'd0, up);
    send_poll(8'd20, up);
  endtask

  // Level bounces away and back: the end of debounce takes the settled level
  task automatic test_bounce_back();
    send_poll(8'd0, ~lvl_released);
    send_poll(8'd30, lvl_released);
  endtask

  // Lock hides every event while the state keeps moving
  task automatic test_locked_events();
    wait_idle();
    write_reg(REG_EVENTS_LOCKED, 16'd1);
    run_gestures(100, 60);
    wait_idle();
    write_reg(REG_EVENTS_LOCKED, 16'd0);
    run_gestures(50, 60);
  endtask

  // Zero delays: debounce still takes a poll, comparisons always pass
  task automatic test_zero_delays();
    wait_idle();
    write_reg(REG_DEBOUNCE_DELAY, 16'd0);
    write_reg(REG_DOUBLE_DELAY, 16'd0);
    write_reg(REG_LONG_DELAY, 16'd0);
    run_gestures(120, 20);
  endtask

  // Hold and click timers run into their ceiling with the largest windows
  task automatic test_timer_saturation();
    logic up;
    logic dn;
    wait_idle();
    write_reg(REG_DEBOUNCE_DELAY, 16'd1);
    write_reg(REG_DOUBLE_DELAY, 16'hFFFF);
    write_reg(REG_LONG_DELAY, 16'hFFFF);
    up = lvl_released;
    dn = ~lvl_released;
    send_poll(8'd0, dn);
    send_poll(8'd255, dn);
    repeat (258) send_poll(8'd255, dn);
    send_poll(8'd0, up);
    send_poll(8'd1, up);
    send_poll(8'd0, dn);
    send_poll(8'd1, dn);
    send_poll(8'd0, up);
    send_poll(8'd1, up);
    repeat (258) send_poll(8'd255, up);
  endtask

  // Largest debounce delay: the wait only ends once its timer saturates
  task automatic test_max_debounce();
    wait_idle();
    write_reg(REG_DEBOUNCE_DELAY, 16'hFFFF);
    repeat (259) send_poll(8'd255, ~lvl_released);
    repeat (259) send_poll(8'd255, lvl_released);
  endtask

  // Upper bits of narrow registers drop, writes past the last index are lost
  task automatic test_register_masking();
    wait_idle();
    for (int a = int'(REG_EVENTS_LOCKED) + 1; a < (1 << CFG_ADDR_WIDTH); a++)
      write_reg(CFG_ADDR_WIDTH'(a), CFG_DATA_WIDTH'($urandom_range(0, 65535)));
    write_reg(REG_DEBOUNCE_DELAY, 16'd10);
    write_reg(REG_DOUBLE_DELAY, 16'd300);
    write_reg(REG_LONG_DELAY, 16'd700);
    write_reg(REG_RELEASED_LEVEL, 16'hFFFE);
    write_reg(REG_EVENTS_LOCKED, 16'hFFFE);
    run_gestures(120, 40);
  endtask

  // Random settings per phase, either polarity of the released level
  task automatic test_random_settings();
    repeat (3) begin
      wait_idle();
      write_reg(REG_DEBOUNCE_DELAY, CFG_DATA_WIDTH'($urandom_range(0, 60)));
      write_reg(REG_DOUBLE_DELAY, CFG_DATA_WIDTH'($urandom_range(0, 800)));
      write_reg(REG_LONG_DELAY, CFG_DATA_WIDTH'($urandom_range(0, 2000)));
      write_reg(REG_RELEASED_LEVEL, CFG_DATA_WIDTH'($urandom_range(0, 65535)));
      write_reg(REG_EVENTS_LOCKED, CFG_DATA_WIDTH'($urandom_range(0, 7) == 0));
      run_gestures(120, $urandom_range(8, 80));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Ready pattern: switch mode each time the phase counter wraps, among always
  // ready, coin toss, mostly stalled and a fixed periodic on/off rhythm
  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == '0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:    out_tready <= (stall_phase[2:0] < 3'd5);
    endcase
  end

  // Check every taken result against the oldest predicted flag set
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_flags.size() == 0) begin
        $error("result 0x%h with no poll awaiting it", out_tdata);
        flag_errors++;
      end else begin
        want = awaited_flags.pop_front();
        for (int i = 0; i < $bits(events_t); i++) begin
          if (out_tdata[i] !== want[i]) begin
            $error("%s: expected %0b, actual %0b", flag_names[i], want[i], out_tdata[i]);
            flag_errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_first_level();
    test_press_long_release();
    test_clicks();
    test_bounce_back();
    wait_idle();
    run_gestures(150, 60);
    test_locked_events();
    test_zero_delays();
    test_timer_saturation();
    test_max_debounce();
    test_register_masking();
    test_random_settings();
    wait_idle();
    repeat (4) @(posedge clk);
    if (flag_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
